>>> sv/gfsp_pkg.sv
// gfsp_pkg: shared types, constants and angle tables for the stick polar block
// depends on nothing; used by every module of gamepad_frame_stick_polar
package gfsp_pkg;

  localparam int ANGLE_STEPS = 45;
  localparam logic [5:0] LAST_STEP = 6'd44;
  localparam logic [6:0] RIGHT_ANGLE = 7'd90;
  localparam logic [7:0] IDLE_ANGLE = 8'd255;
  localparam int IDLE_DIST_INT = 255;
  localparam int CLAMP_DIST_INT = 128;
  localparam logic [14:0] CLAMP_SQ = 15'd16384;
  localparam int SQ_BASE_STEPS = 7;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic [1:0] REG_FRAME_HEADER = 2'd0;
  localparam logic [1:0] REG_LEFT_DZ = 2'd1;
  localparam logic [1:0] REG_RIGHT_DZ = 2'd2;

  localparam logic [7:0] HEADER_RESET = 8'hAA;

  typedef logic [31:0] q31_tab_t [ANGLE_STEPS];

  typedef enum logic [5:0] {
    S_HUNT    = 6'b000001,
    S_COLLECT = 6'b000010,
    S_PREP1   = 6'b000100,
    S_PREP2   = 6'b001000,
    S_CALC    = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  typedef struct packed {
    logic       store;
    logic [2:0] idx;
    logic       prep1;
    logic       prep2;
    logic       step;
    logic [5:0] k;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic hdr_match;
  } status_t;

  // sine or cosine of (k + 0.5) degrees in unsigned q1.31, taylor series
  function automatic q31_tab_t build_trig(input logic want_cos);
    q31_tab_t tab;
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      a = ((PI_Q60 / 64'd360) * 64'(2 * k + 1)) >> 29;
      t = want_cos ? (64'd1 << 31) : a;
      s = t;
      for (int n = 1; n <= 7; n++) begin
        t = (((t * a) >> 31) * a) >> 31;
        if (want_cos) begin
          case (n)
            1: t = t / 64'd2;
            2: t = t / 64'd12;
            3: t = t / 64'd30;
            4: t = t / 64'd56;
            5: t = t / 64'd90;
            6: t = t / 64'd132;
            default: t = t / 64'd182;
          endcase
        end else begin
          case (n)
            1: t = t / 64'd6;
            2: t = t / 64'd20;
            3: t = t / 64'd42;
            4: t = t / 64'd72;
            5: t = t / 64'd110;
            6: t = t / 64'd156;
            default: t = t / 64'd210;
          endcase
        end
        s = (n % 2 == 1) ? (s - t) : (s + t);
      end
      tab[k] = s[31:0];
    end
    return tab;
  endfunction

  localparam q31_tab_t SIN_TAB = build_trig(1'b0);
  localparam q31_tab_t COS_TAB = build_trig(1'b1);

endpackage

>>> sv/gfsp_stick.sv
// gfsp_stick: one stick lane, dead zone, angle count over table, serial square root
// depends on gfsp_pkg; driven by commands from gfsp_ctrl via gfsp_dp
module gfsp_stick #(
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic               clk,
  input  gfsp_pkg::cmd_t     cmd,
  input  logic [7:0]         raw_x,
  input  logic [7:0]         raw_y,
  input  logic [7:0]         deadzone,
  output logic signed [7:0]  x_out,
  output logic signed [8:0]  y_out,
  output logic               detected,
  output logic [7:0]         angle,
  output logic [15:0]        distance
);

  localparam int SQ_STEPS = gfsp_pkg::SQ_BASE_STEPS + DIST_FRAC_BITS;
  localparam int RAD_W = 2 * SQ_STEPS;
  localparam int DW = 9 + DIST_FRAC_BITS;

  logic signed [7:0] x;
  logic signed [8:0] y;
  logic [7:0] lo;
  logic [7:0] hi;
  logic ypos;
  logic swap;
  logic zero;
  logic clamp;
  logic [RAD_W-1:0] rad;
  logic [SQ_STEPS-1:0] root;
  logic [SQ_STEPS+1:0] rem;
  logic [5:0] m;

  logic signed [8:0] xv;
  logic signed [8:0] yv;
  logic [8:0] xa9;
  logic [8:0] ya9;
  logic [7:0] ax;
  logic [7:0] ay;
  logic [15:0] sumsq;
  logic [39:0] prod_lo;
  logic [39:0] prod_hi;
  logic [SQ_STEPS+1:0] rem_sh;
  logic [SQ_STEPS+1:0] trial;
  logic [6:0] m_adj;
  logic [DW-1:0] q;
  logic [DW-1:0] dist_word;

  always_comb begin
    xv = 9'(signed'(raw_x));
    yv = -9'(signed'(raw_y));
    xa9 = xv[8] ? 9'(-xv) : 9'(xv);
    ya9 = yv[8] ? 9'(-yv) : 9'(yv);
    ax = x[7] ? 8'(-9'(x)) : 8'(x);
    ay = y[8] ? 8'(-y) : 8'(y);
    sumsq = 16'(ax) * 16'(ax) + 16'(ay) * 16'(ay);
    prod_lo = 40'(lo) * 40'(gfsp_pkg::COS_TAB[cmd.k]);
    prod_hi = 40'(hi) * 40'(gfsp_pkg::SIN_TAB[cmd.k]);
    rem_sh = {rem[SQ_STEPS-1:0], rad[RAD_W-1 -: 2]};
    trial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep1) begin
      x <= (xa9 < {1'b0, deadzone}) ? 8'sd0 : xv[7:0];
      y <= (ya9 < {1'b0, deadzone}) ? 9'sd0 : yv;
    end
    if (cmd.prep2) begin
      swap <= ax < ay;
      lo <= (ax < ay) ? ax : ay;
      hi <= (ax < ay) ? ay : ax;
      ypos <= !y[8];
      zero <= (ax == 8'd0) && (ay == 8'd0);
      clamp <= sumsq >= 16'(gfsp_pkg::CLAMP_SQ);
      rad <= RAD_W'(sumsq[13:0]) << (2 * DIST_FRAC_BITS);
      root <= '0;
      rem <= '0;
      m <= '0;
    end
    if (cmd.step) begin
      if (prod_lo > prod_hi) begin
        m <= m + 6'd1;
      end
      if (32'(cmd.k) < SQ_STEPS) begin
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[SQ_STEPS-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[SQ_STEPS-2:0], 1'b0};
        end
        rad <= rad << 2;
      end
    end
  end

  always_comb begin
    m_adj = swap ? (gfsp_pkg::RIGHT_ANGLE - 7'(m)) : 7'(m);
    q = DW'(root) + DW'(rem > (SQ_STEPS+2)'(root));
    if (zero) begin
      dist_word = DW'(gfsp_pkg::IDLE_DIST_INT) << DIST_FRAC_BITS;
    end else if (clamp) begin
      dist_word = DW'(gfsp_pkg::CLAMP_DIST_INT) << DIST_FRAC_BITS;
    end else begin
      dist_word = q;
    end
    if (zero) begin
      angle = gfsp_pkg::IDLE_ANGLE;
    end else if (ypos) begin
      angle = 8'(gfsp_pkg::RIGHT_ANGLE - m_adj);
    end else begin
      angle = 8'(gfsp_pkg::RIGHT_ANGLE) + 8'(m_adj);
    end
    distance = 16'(dist_word);
    detected = !zero;
    x_out = x;
    y_out = y;
  end

endmodule

>>> sv/gfsp_dp.sv
// gfsp_dp: datapath with config registers, frame byte store, two stick lanes, result register
// depends on gfsp_pkg and gfsp_stick
module gfsp_dp #(
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  gfsp_pkg::cmd_t      cmd,
  output gfsp_pkg::status_t   status,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output logic signed [7:0]   left_x,
  output logic signed [8:0]   left_y,
  output logic signed [7:0]   right_x,
  output logic signed [8:0]   right_y,
  output logic                left_detected,
  output logic [7:0]          left_angle,
  output logic [15:0]         left_distance,
  output logic                right_detected,
  output logic [7:0]          right_angle,
  output logic [15:0]         right_distance,
  output logic [15:0]         buttons
);

  logic [7:0] frame_header;
  logic [7:0] left_dz;
  logic [7:0] right_dz;
  logic [7:0] fb [6];

  logic signed [7:0] lx;
  logic signed [8:0] ly;
  logic signed [7:0] rx;
  logic signed [8:0] ry;
  logic ldet;
  logic rdet;
  logic [7:0] lang;
  logic [7:0] rang;
  logic [15:0] ldist;
  logic [15:0] rdist;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_header <= gfsp_pkg::HEADER_RESET;
      left_dz <= '0;
      right_dz <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gfsp_pkg::REG_FRAME_HEADER: frame_header <= cfg_data;
        gfsp_pkg::REG_LEFT_DZ: left_dz <= cfg_data;
        gfsp_pkg::REG_RIGHT_DZ: right_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      fb[cmd.idx] <= rx_byte;
    end
  end

  assign status.hdr_match = rx_byte == frame_header;

  gfsp_stick #(.DIST_FRAC_BITS(DIST_FRAC_BITS)) u_left (
    .clk(clk), .cmd(cmd), .raw_x(fb[0]), .raw_y(fb[1]), .deadzone(left_dz),
    .x_out(lx), .y_out(ly), .detected(ldet), .angle(lang), .distance(ldist)
  );

  gfsp_stick #(.DIST_FRAC_BITS(DIST_FRAC_BITS)) u_right (
    .clk(clk), .cmd(cmd), .raw_x(fb[2]), .raw_y(fb[3]), .deadzone(right_dz),
    .x_out(rx), .y_out(ry), .detected(rdet), .angle(rang), .distance(rdist)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      left_x <= lx;
      left_y <= ly;
      right_x <= rx;
      right_y <= ry;
      left_detected <= ldet;
      left_angle <= lang;
      left_distance <= ldist;
      right_detected <= rdet;
      right_angle <= rang;
      right_distance <= rdist;
      buttons <= {fb[5], fb[4]};
    end
  end

endmodule

>>> sv/gfsp_ctrl.sv
// gfsp_ctrl: controller state machine, frame position, step counter, output word valid
// depends on gfsp_pkg; commands gfsp_dp
module gfsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  gfsp_pkg::status_t   status,
  output gfsp_pkg::cmd_t      cmd
);

  gfsp_pkg::state_t state;
  gfsp_pkg::state_t state_next;
  logic [2:0] pos;
  logic [2:0] pos_next;
  logic [5:0] k;
  logic [5:0] k_next;
  logic out_valid_next;
  logic in_take;
  logic out_free;

  assign in_stall = !(state == gfsp_pkg::S_HUNT || state == gfsp_pkg::S_COLLECT);
  assign in_take = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    pos_next = pos;
    k_next = k;
    out_valid_next = out_valid && out_stall;
    cmd = '0;
    cmd.k = k;
    cmd.idx = pos - 3'd1;
    unique case (state)
      gfsp_pkg::S_HUNT: begin
        if (in_take && status.hdr_match) begin
          pos_next = 3'd1;
          state_next = gfsp_pkg::S_COLLECT;
        end
      end
      gfsp_pkg::S_COLLECT: begin
        if (in_take) begin
          cmd.store = 1'b1;
          pos_next = pos + 3'd1;
          if (pos >= 3'd6) begin
            state_next = gfsp_pkg::S_PREP1;
          end
        end
      end
      gfsp_pkg::S_PREP1: begin
        cmd.prep1 = 1'b1;
        state_next = gfsp_pkg::S_PREP2;
      end
      gfsp_pkg::S_PREP2: begin
        cmd.prep2 = 1'b1;
        k_next = '0;
        state_next = gfsp_pkg::S_CALC;
      end
      gfsp_pkg::S_CALC: begin
        cmd.step = 1'b1;
        k_next = k + 6'd1;
        if (k == gfsp_pkg::LAST_STEP) begin
          state_next = gfsp_pkg::S_FIN;
        end
      end
      gfsp_pkg::S_FIN: begin
        if (out_free) begin
          cmd.fin = 1'b1;
          out_valid_next = 1'b1;
          state_next = gfsp_pkg::S_HUNT;
        end
      end
      default: state_next = gfsp_pkg::S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfsp_pkg::S_HUNT;
      pos <= '0;
      k <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos <= pos_next;
      k <= k_next;
      out_valid <= out_valid_next;
    end
  end

  a_calc_ends: assert property (@(posedge clk) disable iff (rst)
    (state == gfsp_pkg::S_CALC && k == gfsp_pkg::LAST_STEP) |=> state == gfsp_pkg::S_FIN)
    else $error("step loop did not end after last step");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == gfsp_pkg::S_FIN && !(out_valid && out_stall)) |=>
      (out_valid && state == gfsp_pkg::S_HUNT))
    else $error("finished word not presented");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == gfsp_pkg::S_COLLECT |-> (pos >= 3'd1 && pos <= 3'd6))
    else $error("frame position out of range");

endmodule

>>> sv/gamepad_frame_stick_polar.sv
// gamepad_frame_stick_polar: top level, joins gfsp_ctrl and gfsp_dp
// depends on gfsp_pkg, gfsp_ctrl, gfsp_dp, gfsp_stick
//
// usage: bytes enter on in_valid/in_stall/rx_byte, one byte per word. the block
// drops bytes until one equals frame_header, then takes the next six bytes as
// left x, left y, right x, right y, buttons low, buttons high. the sixth byte
// starts the computation and one word leaves on out_valid/out_stall.
// bytes are taken in one cycle each while hunting or collecting. after the last
// byte of a frame in_stall stays high through two setup states, 45 steps of
// the table compare (one table entry per cycle, both sticks at once, the square
// root running one digit per cycle alongside) and the load of the output word.
// if the previous word is still stalled at the output, the load waits for it.
// config writes use cfg_valid/cfg_ready (always ready), cfg_index 0..2 for
// header, left dead zone and right dead zone; writes to index 3 are ignored.
// reset (rst, synchronous) returns to hunting with header 0xaa and zero dead
// zones, and drops any pending output word.
module gamepad_frame_stick_polar #(
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  left_x,
  output logic signed [8:0]  left_y,
  output logic signed [7:0]  right_x,
  output logic signed [8:0]  right_y,
  output logic               left_detected,
  output logic [7:0]         left_angle,
  output logic [15:0]        left_distance,
  output logic               right_detected,
  output logic [7:0]         right_angle,
  output logic [15:0]        right_distance,
  output logic [15:0]        buttons,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  gfsp_pkg::cmd_t cmd;
  gfsp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  gfsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  gfsp_dp #(.DIST_FRAC_BITS(DIST_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .rx_byte(rx_byte),
    .cfg_write(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .left_x(left_x), .left_y(left_y), .right_x(right_x), .right_y(right_y),
    .left_detected(left_detected), .left_angle(left_angle),
    .left_distance(left_distance), .right_detected(right_detected),
    .right_angle(right_angle), .right_distance(right_distance), .buttons(buttons)
  );

endmodule
